@@ hw/rtl/key_value_map_table_core_defines.svh @@
// ---------------------------------------------------------------------------
// Key/value map table assertion macros
// Shared assertion shorthands, sampled on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef KEY_VALUE_MAP_TABLE_CORE_DEFINES_SVH
`define KEY_VALUE_MAP_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Condition holds at every edge
`define KVMT_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("kvmt assertion failed");
// Antecedent implies consequent in the same cycle
`define KVMT_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kvmt assertion failed");
// Antecedent implies consequent in the next cycle
`define KVMT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kvmt assertion failed");
`else
`define KVMT_ASSERT(lbl, cond)
`define KVMT_ASSERT_IMPLY(lbl, ante, cons)
`define KVMT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ hw/rtl/kvmt_pkg.sv @@
// ---------------------------------------------------------------------------
// Key/value map table package
// Sizes, operation codes, cell commands and payload types.
// ---------------------------------------------------------------------------
package kvmt_pkg;

	localparam int CAPACITY = 16;
	localparam int KEY_W    = 32;
	localparam int VAL_W    = 32;
	localparam int FUNC_W   = 3;
	localparam int IDX_W    = 4;
	localparam int CNT_W    = 5;

	localparam logic [FUNC_W-1:0] FN_INSERT       = 3'd0;
	localparam logic [FUNC_W-1:0] FN_UPDATE       = 3'd1;
	localparam logic [FUNC_W-1:0] FN_INSERT_OR_UPD = 3'd2;
	localparam logic [FUNC_W-1:0] FN_ERASE        = 3'd3;
	localparam logic [FUNC_W-1:0] FN_CONTAINS     = 3'd4;
	localparam logic [FUNC_W-1:0] FN_GET_BY_KEY   = 3'd5;
	localparam logic [FUNC_W-1:0] FN_GET_BY_INDEX = 3'd6;

	localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(CAPACITY);

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_PULL,
		CELL_WRITE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     valid;
	} cell_ctrl_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  new_value;
		logic [IDX_W-1:0]  index;
	} req_t;

	typedef struct packed {
		logic              ok;
		logic [KEY_W-1:0]  out_key;
		logic [VAL_W-1:0]  out_value;
		logic [CNT_W-1:0]  entry_count;
	} rsp_t;

endpackage

@@ hw/rtl/kvmt_cell.sv @@
// ---------------------------------------------------------------------------
// Key/value map table cell
// Holds one pair, compares it with the request key and moves it to or from
// a neighbor on command.
// ---------------------------------------------------------------------------
module kvmt_cell
	import kvmt_pkg::*;
(
	input  logic             clk,
	input  cell_ctrl_t       ctrl,
	input  logic [KEY_W-1:0] req_key,
	input  logic [VAL_W-1:0] req_value,
	input  logic [KEY_W-1:0] left_key,
	input  logic [VAL_W-1:0] left_value,
	input  logic [KEY_W-1:0] right_key,
	input  logic [VAL_W-1:0] right_value,
	input  logic             prefix_in,
	output logic             prefix_out,
	output logic             hit,
	output logic [KEY_W-1:0] key,
	output logic [VAL_W-1:0] value
);

	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;

	assign hit        = ctrl.valid && (key_q == req_key);
	// mark this cell and every later one once a hit has been seen
	assign prefix_out = prefix_in | hit;
	assign key        = key_q;
	assign value      = value_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_PUSH: begin
				key_q   <= left_key;
				value_q <= left_value;
			end
			CELL_PULL: begin
				key_q   <= right_key;
				value_q <= right_value;
			end
			CELL_WRITE: begin
				value_q <= req_value;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ hw/rtl/key_value_map_table_core.sv @@
// ---------------------------------------------------------------------------
// Key/value map table core
// Bounded newest-first key/value table built as a row of compare/shift cells.
// ---------------------------------------------------------------------------
// Usage:
//   req (valid/ready) carries one operation item: func, key, new_value, index.
//   rsp (valid/ready) returns exactly one result item per request: ok,
//   out_key, out_value and the pair count after the operation.
//   An accepted item is held in a request register; every cell compares its
//   key against it at once, and when the output register is empty or being
//   drained the row shifts or writes as the operation needs and the result
//   is loaded into the output register.
//   Throughput is one item per cycle: the request register frees in the
//   same cycle its item executes, which needs the output register to be
//   empty or being drained.
//   When rsp_ready is low the result is held, at most one further item waits
//   in the request register, and req_ready then drops.
//   Reset empties the table (pair count zero) and clears both valid flags;
//   cell contents are not cleared, since positions at or above the count
//   are never read.
// ---------------------------------------------------------------------------
`include "key_value_map_table_core_defines.svh"

module key_value_map_table_core
	import kvmt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic             busy_q;
	req_t             req_q;
	logic             out_valid_q;
	rsp_t             rsp_q;
	logic [CNT_W-1:0] count_q;

	logic             exec;
	logic             found;
	logic             full;
	logic             do_ins;
	logic             do_upd;
	logic             do_era;
	logic             idx_ok;
	logic [CNT_W-1:0] count_next;
	logic [VAL_W-1:0] key_value;
	logic [KEY_W-1:0] idx_key;
	logic [VAL_W-1:0] idx_value;
	rsp_t             rsp_next;

	cell_ctrl_t       ctrl [CAPACITY];
	logic [KEY_W-1:0] cell_key [CAPACITY];
	logic [VAL_W-1:0] cell_value [CAPACITY];
	logic [CAPACITY-1:0] hit;
	logic [CAPACITY:0]   prefix;

	assign exec      = busy_q && (!out_valid_q || rsp_ready);
	assign req_ready = !busy_q || exec;
	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

	assign found  = prefix[CAPACITY];
	assign full   = (count_q == COUNT_FULL);
	assign do_ins = exec && !found && !full
		&& ((req_q.func == FN_INSERT) || (req_q.func == FN_INSERT_OR_UPD));
	assign do_upd = exec && found
		&& ((req_q.func == FN_UPDATE) || (req_q.func == FN_INSERT_OR_UPD));
	assign do_era = exec && found && (req_q.func == FN_ERASE);
	assign idx_ok = ({1'b0, req_q.index} < count_q);

	assign prefix[0] = 1'b0;

	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			logic [KEY_W-1:0] lkey;
			logic [VAL_W-1:0] lvalue;
			logic [KEY_W-1:0] rkey;
			logic [VAL_W-1:0] rvalue;

			if (i == 0) begin : g_head
				assign lkey   = req_q.key;
				assign lvalue = req_q.new_value;
			end else begin : g_body
				assign lkey   = cell_key[i-1];
				assign lvalue = cell_value[i-1];
			end

			if (i == CAPACITY - 1) begin : g_tail
				assign rkey   = cell_key[i];
				assign rvalue = cell_value[i];
			end else begin : g_inner
				assign rkey   = cell_key[i+1];
				assign rvalue = cell_value[i+1];
			end

			always_comb begin
				ctrl[i].valid = (CNT_W'(i) < count_q);
				if (do_ins) begin
					ctrl[i].op = CELL_PUSH;
				end else if (do_era && prefix[i+1]) begin
					ctrl[i].op = CELL_PULL;
				end else if (do_upd && hit[i]) begin
					ctrl[i].op = CELL_WRITE;
				end else begin
					ctrl[i].op = CELL_HOLD;
				end
			end

			kvmt_cell u_cell (
				.clk         (clk),
				.ctrl        (ctrl[i]),
				.req_key     (req_q.key),
				.req_value   (req_q.new_value),
				.left_key    (lkey),
				.left_value  (lvalue),
				.right_key   (rkey),
				.right_value (rvalue),
				.prefix_in   (prefix[i]),
				.prefix_out  (prefix[i+1]),
				.hit         (hit[i]),
				.key         (cell_key[i]),
				.value       (cell_value[i])
			);
		end
	endgenerate

	// one-hot reads: hit vector for lookups, decoded index for position reads
	always_comb begin
		key_value = '0;
		idx_key   = '0;
		idx_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (hit[i]) begin
				key_value = key_value | cell_value[i];
			end
			if (req_q.index == IDX_W'(i)) begin
				idx_key   = idx_key | cell_key[i];
				idx_value = idx_value | cell_value[i];
			end
		end
	end

	always_comb begin
		count_next = count_q;
		if (do_ins) begin
			count_next = count_q + 1'b1;
		end else if (do_era) begin
			count_next = count_q - 1'b1;
		end

		rsp_next.ok          = 1'b0;
		rsp_next.out_key     = req_q.key;
		rsp_next.out_value   = '0;
		rsp_next.entry_count = count_next;
		case (req_q.func)
			FN_INSERT:        rsp_next.ok = !found && !full;
			FN_UPDATE:        rsp_next.ok = found;
			FN_INSERT_OR_UPD: rsp_next.ok = found || !full;
			FN_ERASE:         rsp_next.ok = found;
			FN_CONTAINS:      rsp_next.ok = found;
			FN_GET_BY_KEY: begin
				rsp_next.ok        = found;
				rsp_next.out_value = key_value;
			end
			FN_GET_BY_INDEX: begin
				if (idx_ok) begin
					rsp_next.ok        = 1'b1;
					rsp_next.out_key   = idx_key;
					rsp_next.out_value = idx_value;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (req_valid && req_ready) begin
				busy_q <= 1'b1;
			end else if (exec) begin
				busy_q <= 1'b0;
			end
			if (exec) begin
				out_valid_q <= 1'b1;
				count_q     <= count_next;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (exec) begin
			rsp_q <= rsp_next;
		end
	end

	`KVMT_ASSERT(a_count_bound, count_q <= COUNT_FULL)
	`KVMT_ASSERT(a_single_hit, $onehot0(hit))
	`KVMT_ASSERT_NEXT(a_exec_loads_result, exec, out_valid_q)
	`KVMT_ASSERT_NEXT(a_item_kept, busy_q && !exec, busy_q && $stable(req_q))
	`KVMT_ASSERT_NEXT(a_count_only_on_exec, !exec, count_q == $past(count_q))

endmodule

@@ bench/tb_top.sv @@
// ---------------------------------------------------------------------------
// Key/value map table testbench
// Drives insert, update, insert-or-update, erase and lookup items through the
// request channel and checks each result against a newest-first table kept
// here. Directed corner items come first, then rounds that fill the table
// past capacity, drain it, mix operations and throw in noise. Random idling
// and stalling on both channels is applied over the first two thirds of the run.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
	import kvmt_pkg::*;
();

	localparam int RANDOM_ITEMS = 1900;
	localparam int KEY_POOL     = 24;
	localparam int LIMIT_CYCLES = 400000;
	localparam int MAX_PRINTS   = 30;
	localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	key_value_map_table_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	req_t op_q[$];
	rsp_t pending_results[$];
	logic [KEY_W-1:0] key_pool [KEY_POOL];
	logic [KEY_W-1:0] stray_keys[$];

	// Table copy, newest first
	logic [KEY_W-1:0] map_keys [CAPACITY];
	logic [VAL_W-1:0] map_vals [CAPACITY];
	int map_count = 0;

	int n_items = 0;
	int n_accepted = 0;
	int n_results = 0;
	int n_errors = 0;
	int n_ok = 0;
	int n_full_reject = 0;
	int n_emptied = 0;
	int cycles = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic rsp_t map_apply(req_t r);
		int pos;
		int i;
		rsp_t o;
		pos = -1;
		for (i = 0; i < map_count; i++) begin
			if (pos < 0 && map_keys[i] == r.key) pos = i;
		end
		o.ok = 1'b0;
		o.out_key = r.key;
		o.out_value = '0;
		case (r.func)
			FN_INSERT, FN_INSERT_OR_UPD: begin
				if (pos >= 0) begin
					if (r.func == FN_INSERT_OR_UPD) begin
						map_vals[pos] = r.new_value;
						o.ok = 1'b1;
					end
				end else if (map_count < CAPACITY) begin
					for (i = map_count; i > 0; i--) begin
						map_keys[i] = map_keys[i-1];
						map_vals[i] = map_vals[i-1];
					end
					map_keys[0] = r.key;
					map_vals[0] = r.new_value;
					map_count++;
					o.ok = 1'b1;
				end else begin
					n_full_reject++;
				end
			end
			FN_UPDATE: begin
				if (pos >= 0) begin
					map_vals[pos] = r.new_value;
					o.ok = 1'b1;
				end
			end
			FN_ERASE: begin
				if (pos >= 0) begin
					// close the gap, keep the order
					for (i = pos; i + 1 < map_count; i++) begin
						map_keys[i] = map_keys[i+1];
						map_vals[i] = map_vals[i+1];
					end
					map_count--;
					o.ok = 1'b1;
					if (map_count == 0) n_emptied++;
				end
			end
			FN_CONTAINS: o.ok = (pos >= 0);
			FN_GET_BY_KEY: begin
				if (pos >= 0) begin
					o.out_value = map_vals[pos];
					o.ok = 1'b1;
				end
			end
			FN_GET_BY_INDEX: begin
				if (int'(r.index) < map_count) begin
					o.out_key = map_keys[r.index];
					o.out_value = map_vals[r.index];
					o.ok = 1'b1;
				end
			end
			default: ;
		endcase
		o.entry_count = CNT_W'(map_count);
		if (o.ok) n_ok++;
		return o;
	endfunction

	task automatic queue_op(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v, logic [IDX_W-1:0] ix);
		req_t r;
		r.func = f;
		r.key = k;
		r.new_value = v;
		r.index = ix;
		op_q.push_back(r);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(9) == 0) return $urandom;
		return key_pool[$urandom_range(KEY_POOL-1)];
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		n_errors++;
		if (n_errors <= MAX_PRINTS)
			$display("result %0d: %s got 0x%08h, want 0x%08h", n_results, field, got, want);
	endtask

	function automatic int idle_phase();
		int p;
		p = (n_items == 0) ? 0 : (n_accepted * 3) / n_items;
		return (p > 2) ? 2 : p;
	endfunction

	function automatic int send_idle_pct();
		case (idle_phase())
			0: return 26;
			1: return 70;
			default: return 0;
		endcase
	endfunction

	function automatic int recv_stall_pct();
		case (idle_phase())
			0: return 70;
			1: return 26;
			default: return 0;
		endcase
	endfunction

	// Request driver: advance to the next item only once the current one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				pending_results.push_back(map_apply(req));
				n_accepted <= n_accepted + 1;
			end
			if (!req_valid || req_ready) begin
				if (op_q.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
					req_valid <= 1'b1;
					req <= op_q.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				n_results <= n_results + 1;
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected item, out_key", rsp.out_key, '0);
				end else begin
					want = pending_results.pop_front();
					if (rsp.ok !== want.ok)
						report_mismatch("ok", 32'(rsp.ok), 32'(want.ok));
					if (rsp.out_key !== want.out_key)
						report_mismatch("out_key", rsp.out_key, want.out_key);
					if (rsp.out_value !== want.out_value)
						report_mismatch("out_value", rsp.out_value, want.out_value);
					if (rsp.entry_count !== want.entry_count)
						report_mismatch("entry_count", 32'(rsp.entry_count),
							32'(want.entry_count));
				end
			end
			rsp_ready <= ($urandom_range(99) >= recv_stall_pct());
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout: %0d of %0d results seen", n_results, n_items);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int i;
		int j;
		int n;
		int base;
		int kind;
		logic [FUNC_W-1:0] f;
		logic [KEY_W-1:0] k;

		for (i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom;
		key_pool[0] = '0;
		key_pool[1] = '1;

		// Directed corners: empty table, extremes, duplicates, misses, unused code
		queue_op(FN_GET_BY_INDEX, 32'h0000_1111, 32'h0, 4'd0);
		queue_op(FN_CONTAINS, 32'h0, 32'h0, 4'd0);
		queue_op(FN_UNUSED, '1, '1, 4'd15);
		queue_op(FN_INSERT, 32'h0, 32'h0, 4'd0);
		queue_op(FN_INSERT, '1, '1, 4'd15);
		queue_op(FN_INSERT, 32'h0, 32'h5, 4'd0);
		queue_op(FN_UPDATE, 32'h0, '1, 4'd0);
		queue_op(FN_UPDATE, 32'h1234_5678, 32'h9abc_def0, 4'd0);
		queue_op(FN_INSERT_OR_UPD, '1, 32'h0, 4'd0);
		queue_op(FN_INSERT_OR_UPD, 32'h5a5a_5a5a, 32'h3c3c_3c3c, 4'd0);
		queue_op(FN_GET_BY_KEY, 32'h0, 32'h0, 4'd0);
		queue_op(FN_GET_BY_KEY, 32'h8000_0000, 32'h0, 4'd0);
		queue_op(FN_GET_BY_INDEX, 32'h0, 32'h0, 4'd0);
		queue_op(FN_GET_BY_INDEX, 32'h0, 32'h0, 4'd2);
		queue_op(FN_GET_BY_INDEX, 32'h0, 32'h0, 4'd3);
		queue_op(FN_GET_BY_INDEX, 32'h7777_7777, 32'h0, 4'd15);
		queue_op(FN_ERASE, '1, 32'h0, 4'd0);
		queue_op(FN_ERASE, 32'hdead_0001, 32'h0, 4'd0);
		queue_op(FN_GET_BY_INDEX, 32'h0, 32'h0, 4'd1);
		queue_op(FN_CONTAINS, 32'h0, 32'h0, 4'd0);
		queue_op(FN_ERASE, 32'h0, 32'h0, 4'd0);
		queue_op(FN_ERASE, 32'h5a5a_5a5a, 32'h0, 4'd0);
		queue_op(FN_ERASE, 32'h5a5a_5a5a, 32'h0, 4'd0);
		n = op_q.size() + RANDOM_ITEMS;

		while (op_q.size() < n) begin
			kind = $urandom_range(9);
			base = $urandom_range(KEY_POOL-1);
			if (kind <= 2) begin
				// fill past capacity with distinct pool keys
				for (j = 0; j < 16 + $urandom_range(6); j++) begin
					f = $urandom_range(1) ? FN_INSERT : FN_INSERT_OR_UPD;
					queue_op(f, key_pool[(base + j) % KEY_POOL], $urandom,
						IDX_W'($urandom));
				end
				queue_op(FN_GET_BY_INDEX, pick_key(), $urandom, 4'd15);
				queue_op(FN_GET_BY_KEY, pick_key(), $urandom, IDX_W'($urandom));
			end else if (kind <= 4) begin
				// drain: erase every pool key and anything stray
				for (j = 0; j < KEY_POOL; j++) begin
					queue_op(FN_ERASE, key_pool[(base + j) % KEY_POOL], $urandom,
						IDX_W'($urandom));
					if ($urandom_range(3) == 0)
						queue_op(FN_GET_BY_INDEX, pick_key(), $urandom,
							IDX_W'($urandom));
				end
				while (stray_keys.size() != 0)
					queue_op(FN_ERASE, stray_keys.pop_front(), $urandom, IDX_W'($urandom));
				queue_op(FN_GET_BY_INDEX, pick_key(), $urandom, 4'd0);
			end else if (kind <= 7) begin
				for (j = 0; j < 30; j++) begin
					f = FUNC_W'($urandom_range(6));
					k = pick_key();
					queue_op(f, k, $urandom, IDX_W'($urandom));
					if (f == FN_INSERT || f == FN_INSERT_OR_UPD) stray_keys.push_back(k);
				end
			end else begin
				// noise: any code, any key
				for (j = 0; j < 15; j++) begin
					f = FUNC_W'($urandom);
					k = $urandom_range(1) ? 32'($urandom) : pick_key();
					queue_op(f, k, $urandom, IDX_W'($urandom));
					if (f == FN_INSERT || f == FN_INSERT_OR_UPD) stray_keys.push_back(k);
				end
			end
		end
		n_items = op_q.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (n_results < n_items) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Ran %0d table operations in %0d cycles: %0d succeeded, %0d inserts refused",
			n_items, cycles, n_ok, n_full_reject);
		$display("on a full table, table emptied by erase %0d times.", n_emptied);
		if (n_errors == 0 && pending_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", n_errors, pending_results.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
